>>> rtl/pbd_pkg.sv
// ----------------------------------------------------------------------------
// PackBits decoder package
// Shared types, widths and constants of the scanline run decoder.
// ----------------------------------------------------------------------------
package pbd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COL_W   = 12;
  localparam int unsigned LINE_W  = 16;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BODY_LENGTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COMP_MODE   = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [COL_W-1:0]  LINE_WIDTH_RST  = 12'd320;
  localparam logic [LINE_W-1:0] MAX_LINES_RST   = 16'd200;
  localparam logic [LEN_W-1:0]  BODY_LENGTH_RST = 32'd0;
  localparam logic [BYTE_W-1:0] COMP_MODE_RST   = 8'd1;

  localparam logic [BYTE_W-1:0] COMP_MODE_RLE = 8'd1;
  localparam logic [COL_W-1:0]  MIN_WIDTH     = 12'd128;
  localparam logic [LINE_W-1:0] LINE_MAX      = 16'hFFFF;

  localparam int unsigned CMD_DEPTH_DEF = 4;
  localparam int unsigned OUT_DEPTH_DEF = 4;

  typedef struct packed {
    logic [COL_W-1:0]  line_width;
    logic [LINE_W-1:0] max_lines;
    logic [LEN_W-1:0]  body_length;
    logic [BYTE_W-1:0] comp_mode;
  } cfg_t;

  // One run to be placed on the scanlines: a value and a count of 1..128.
  typedef struct packed {
    logic [BYTE_W-1:0] pixel_value;
    logic [BYTE_W-1:0] run_count;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel_value;
    logic [BYTE_W-1:0] run_count;
    logic [COL_W-1:0]  start_column;
    logic [LINE_W-1:0] line_number;
    logic              end_of_line;
    logic              line_visible;
    logic              last;
  } res_t;

endpackage

>>> rtl/pbd_fifo.sv
// ----------------------------------------------------------------------------
// PackBits decoder queue
// Small shift-register queue; the oldest word always sits in slot zero.
// ----------------------------------------------------------------------------
module pbd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = slot_r[0];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (do_pop) begin
        if (do_push && (CW'(i) == cnt_r - 1'b1)) begin
          slot_r[i] <= wdata;
        end else if (i < DEPTH - 1) begin
          slot_r[i] <= slot_r[(i < DEPTH - 1) ? i + 1 : i];
        end
      end else if (do_push && (CW'(i) == cnt_r)) begin
        slot_r[i] <= wdata;
      end
    end
  end

endmodule

>>> rtl/pbd_front.sv
// ----------------------------------------------------------------------------
// PackBits decoder front end
// Takes body bytes, tracks the control phase and issues one run per data byte.
// ----------------------------------------------------------------------------
module pbd_front
  import pbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              accept,
  input  logic [BYTE_W-1:0] data_byte,
  output logic              cmd_push,
  output cmd_t              cmd
);

  localparam logic [1:0] PH_CONTROL = 2'd0;
  localparam logic [1:0] PH_LITERAL = 2'd1;
  localparam logic [1:0] PH_REPEAT  = 2'd2;

  localparam logic [BYTE_W-1:0] NOOP_CODE = 8'h80;

  logic [1:0]        phase_r, phase_nxt;
  logic [BYTE_W-1:0] left_r, left_nxt;
  logic [LEN_W-1:0]  consumed_r, consumed_nxt;
  logic              live;

  // A byte counts only in decode mode and while the body is not exhausted.
  assign live = accept && (cfg.comp_mode == COMP_MODE_RLE) &&
                (consumed_r < cfg.body_length);

  always_comb begin
    phase_nxt       = phase_r;
    left_nxt        = left_r;
    consumed_nxt    = consumed_r;
    cmd_push        = 1'b0;
    cmd.pixel_value = data_byte;
    cmd.run_count   = 8'd1;
    if (live) begin
      consumed_nxt = consumed_r + 1'b1;
      unique case (phase_r)
        PH_LITERAL: begin
          cmd_push = 1'b1;
          if (left_r != '0) begin
            left_nxt = left_r - 1'b1;
          end
          if (left_r <= 8'd1) begin
            phase_nxt = PH_CONTROL;
          end
        end
        PH_REPEAT: begin
          cmd_push      = 1'b1;
          cmd.run_count = left_r;
          left_nxt      = '0;
          phase_nxt     = PH_CONTROL;
        end
        default: begin
          if (data_byte == NOOP_CODE) begin
            phase_nxt = phase_r;
          end else if (data_byte < NOOP_CODE) begin
            left_nxt  = data_byte + 1'b1;
            phase_nxt = PH_LITERAL;
          end else begin
            // Two's complement negate plus one: 257 - b, kept to 8 bits.
            left_nxt  = (~data_byte) + 8'd2;
            phase_nxt = PH_REPEAT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CONTROL;
      left_r     <= '0;
      consumed_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      left_r     <= left_nxt;
      consumed_r <= consumed_nxt;
    end
  end

endmodule

>>> rtl/pbd_back.sv
// ----------------------------------------------------------------------------
// PackBits decoder back end
// Places runs on scanlines, splitting a run that crosses the end of a line.
// ----------------------------------------------------------------------------
module pbd_back
  import pbd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic cmd_empty,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              split_r, split_nxt;
  logic [BYTE_W-1:0] split_cnt_r, split_cnt_nxt;

  logic [COL_W-1:0]  width;
  logic              wrap;
  logic [COL_W-1:0]  col_eff;
  logic [LINE_W-1:0] line_eff;
  logic [LINE_W-1:0] line_inc;
  logic [COL_W-1:0]  rem;
  logic [COL_W-1:0]  cnt_ext;
  logic              active;

  function automatic logic [LINE_W-1:0] sat_inc(input logic [LINE_W-1:0] v);
    sat_inc = (v == LINE_MAX) ? v : v + 1'b1;
  endfunction

  assign width    = (cfg.line_width < MIN_WIDTH) ? MIN_WIDTH : cfg.line_width;
  // A column already at or past the width (width lowered mid-line) closes the line.
  assign wrap     = (col_r >= width);
  assign col_eff  = wrap ? '0 : col_r;
  assign line_eff = wrap ? sat_inc(line_r) : line_r;
  assign line_inc = sat_inc(line_eff);
  assign rem      = width - col_eff;
  assign cnt_ext  = {{(COL_W - BYTE_W){1'b0}}, cmd.run_count};
  assign active   = !cmd_empty && !res_full;
  assign res_push = active;

  always_comb begin
    col_nxt          = col_r;
    line_nxt         = line_r;
    split_nxt        = split_r;
    split_cnt_nxt    = split_cnt_r;
    cmd_pop          = 1'b0;
    res.pixel_value  = cmd.pixel_value;
    res.run_count    = cmd.run_count;
    res.start_column = col_eff;
    res.line_number  = line_eff;
    res.end_of_line  = 1'b0;
    res.line_visible = (line_eff < cfg.max_lines);
    res.last         = 1'b1;
    if (split_r) begin
      // Second half of a split run always starts a fresh line at column zero.
      res.run_count    = split_cnt_r;
      res.start_column = '0;
      res.line_number  = line_r;
      res.line_visible = (line_r < cfg.max_lines);
      if (active) begin
        col_nxt   = {{(COL_W - BYTE_W){1'b0}}, split_cnt_r};
        split_nxt = 1'b0;
        cmd_pop   = 1'b1;
      end
    end else if (cnt_ext < rem) begin
      if (active) begin
        col_nxt  = col_eff + cnt_ext;
        line_nxt = line_eff;
        cmd_pop  = 1'b1;
      end
    end else if (cnt_ext == rem) begin
      res.end_of_line = 1'b1;
      if (active) begin
        col_nxt  = '0;
        line_nxt = line_inc;
        cmd_pop  = 1'b1;
      end
    end else begin
      // rem is below the count here, so it fits in the count width.
      res.run_count   = rem[BYTE_W-1:0];
      res.end_of_line = 1'b1;
      res.last        = 1'b0;
      if (active) begin
        col_nxt       = '0;
        line_nxt      = line_inc;
        split_nxt     = 1'b1;
        split_cnt_nxt = cmd.run_count - rem[BYTE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      line_r  <= '0;
      split_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      line_r  <= line_nxt;
      split_r <= split_nxt;
    end
  end

  always_ff @(posedge clk) begin
    split_cnt_r <= split_cnt_nxt;
  end

endmodule

>>> rtl/packbits_scanline_decoder.sv
// ----------------------------------------------------------------------------
// PackBits scanline run decoder
// Turns a PackBits compressed image body into per-scanline run descriptors.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive in_data_byte and raise in_push; a word is taken at a
//   clock edge where in_push is high and in_full is low. One byte per cycle
//   is sustained while in_full stays low.
//   Result queue: while out_empty is low the oldest run descriptor is on the
//   out_ ports; raising out_pop takes it. out_last marks the final run that
//   a byte caused. A data byte yields one run, or two when the run crosses
//   the end of a scanline; control bytes yield none.
//   Each run passes through the run queue and then the output queue before
//   it reaches the out_ ports. The back end places one run per cycle while
//   the run queue holds a run and the output queue has room; a split run is
//   placed as two runs. Throughput is one byte per cycle but for split runs.
//   If the result side stalls, the output queue and then the run queue
//   fill, and in_full rises; nothing is dropped.
//   Configuration: write cfg_wdata to register cfg_addr with cfg_wr_en,
//   only while the block is idle. Reset clears both queues and the decode
//   position and loads the default register values.
// ----------------------------------------------------------------------------
module packbits_scanline_decoder
  import pbd_pkg::*;
#(
  parameter int unsigned CMD_DEPTH = CMD_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_push,
  input  logic [BYTE_W-1:0]    in_data_byte,
  output logic                 in_full,
  input  logic                 out_pop,
  output logic                 out_empty,
  output logic [BYTE_W-1:0]    out_pixel_value,
  output logic [BYTE_W-1:0]    out_run_count,
  output logic [COL_W-1:0]     out_start_column,
  output logic [LINE_W-1:0]    out_line_number,
  output logic                 out_end_of_line,
  output logic                 out_line_visible,
  output logic                 out_last
);

  cfg_t cfg_r;
  cmd_t cmd_in;
  cmd_t cmd_head;
  res_t res_in;
  res_t res_head;
  logic cmd_push;
  logic cmd_full;
  logic cmd_empty;
  logic cmd_pop;
  logic res_push;
  logic res_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_width  <= LINE_WIDTH_RST;
      cfg_r.max_lines   <= MAX_LINES_RST;
      cfg_r.body_length <= BODY_LENGTH_RST;
      cfg_r.comp_mode   <= COMP_MODE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_LINE_WIDTH:  cfg_r.line_width  <= cfg_wdata[COL_W-1:0];
        CFG_MAX_LINES:   cfg_r.max_lines   <= cfg_wdata[LINE_W-1:0];
        CFG_BODY_LENGTH: cfg_r.body_length <= cfg_wdata[LEN_W-1:0];
        CFG_COMP_MODE:   cfg_r.comp_mode   <= cfg_wdata[BYTE_W-1:0];
      endcase
    end
  end

  assign in_full = cmd_full;

  pbd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .accept    (in_push && !cmd_full),
    .data_byte (in_data_byte),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  pbd_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_head),
    .empty (cmd_empty)
  );

  pbd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  pbd_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_head),
    .empty (out_empty)
  );

  assign out_pixel_value  = res_head.pixel_value;
  assign out_run_count    = res_head.run_count;
  assign out_start_column = res_head.start_column;
  assign out_line_number  = res_head.line_number;
  assign out_end_of_line  = res_head.end_of_line;
  assign out_line_visible = res_head.line_visible;
  assign out_last         = res_head.last;

endmodule
